// ----- sv/assert_macros.svh -----
// Assertion macros used by the box filter checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BF3_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("bf3 assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BF3_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("bf3 assertion failed");

`endif

// ----- sv/bf3_pkg.sv -----
// Types and constants of the 3x3 RGB box filter.
`timescale 1ns / 1ps
`default_nettype none

package bf3_pkg;

  localparam int PIX_W     = 24;
  localparam int CH_W      = 8;
  localparam int ROW_W     = 16;
  localparam int COL_OUT_W = 10;
  localparam int CFG_W_W   = 11;
  localparam int CFG_H_W   = 16;
  localparam int SUM_W     = 12;

  localparam logic [CFG_W_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [CFG_H_W-1:0] HEIGHT_RST = 16'd480;

  // Register index, taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Input item kinds
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // floor(x / 9) == (x * 3641) >> 15 for every x below 32768
  localparam logic [SUM_W-1:0] DIV9_MUL   = 12'd3641;
  localparam int               DIV9_SHIFT = 15;

  // Output queue
  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = 3;
  localparam int OQ_CNT_W = 4;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic             req_type;
    logic [CH_W-1:0]  pixel_c0;
    logic [CH_W-1:0]  pixel_c1;
    logic [CH_W-1:0]  pixel_c2;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]      out_c0;
    logic [CH_W-1:0]      out_c1;
    logic [CH_W-1:0]      out_c2;
    logic [ROW_W-1:0]     out_row;
    logic [COL_OUT_W-1:0] out_col;
    logic                 frame_end;
  } out_item_t;

  // One line store entry: newest row (a) and the row above it (b)
  typedef struct packed {
    pix_t a;
    pix_t b;
  } line_entry_t;

  // Position and kind of a pixel on its way to the output
  typedef struct packed {
    logic                 interior;
    logic                 last;
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
  } tag_t;

  typedef struct packed {
    logic                empty;
    logic [OQ_CNT_W-1:0] count;
  } oq_stat_t;

endpackage

`default_nettype wire

// ----- sv/bf3_line_mem.sv -----
// Line store memory: both previous rows per column, registered read, write bypass.
`timescale 1ns / 1ps
`default_nettype none

module bf3_line_mem
  import bf3_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  line_entry_t                   wr_data,
  output line_entry_t                   rd_data
);

  line_entry_t mem [DEPTH];
  line_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A write landing on the entry being read hands its data straight over
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- sv/bf3_out_fifo.sv -----
// Output queue holding finished result pixels until the receiver takes them.
`timescale 1ns / 1ps
`default_nettype none

module bf3_out_fifo
  import bf3_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  out_item_t push_data,
  input  wire logic pop,
  output out_item_t pop_data,
  output oq_stat_t  stat
);

  out_item_t             buf_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [OQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CNT_W-1:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data   = buf_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

endmodule

`default_nettype wire

// ----- sv/box_filter_3x3_rgb_top.sv -----
// Top level of the streaming 3x3 mean filter over RGB pixels in raster order.
//
// Use:
//  - in_valid/in_ready carry one transaction per pixel (req_type pixel) or flush
//    (req_type flush); out_valid/out_ready carry one result pixel per transaction.
//  - Results trail the input by one row and one column. The first result comes
//    with transaction image_width + 1 of a frame; after the last pixel,
//    image_width + 1 flush transactions drain the frame. Border pixels pass
//    through, interior pixels get the truncated mean of their 3x3 neighborhood.
//  - Throughput: one transaction per clock while in_ready is high, set by the
//    line store, which takes one read and one write per pixel. A result shows
//    on out_valid once it has passed the line store read, window update,
//    window sums and divide by 9 into the output queue.
//  - When the receiver stalls, finished results wait in an 8-deep output queue;
//    in_ready drops once queue plus pipeline hold 8 transactions.
//  - APB registers: 0x0 image_width, 0x4 image_height. Any write restarts the
//    frame; write only while the block is idle.
//  - Synchronous reset: width 640, height 480, frame position and window
//    cleared. Line store contents stay undefined until written; no entry is
//    read for a result before the frame has written it.
`timescale 1ns / 1ps
`default_nettype none

module box_filter_3x3_rgb_top
  import bf3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  // wide enough for the width register and for MAX_WIDTH itself
  localparam int EW = (CW + 1 > CFG_W_W) ? CW + 1 : CFG_W_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W_W-1:0] width_r, width_nxt;
  logic [CFG_H_W-1:0] height_r, height_nxt;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      REG_WIDTH:  prdata = {{(32 - CFG_W_W){1'b0}}, width_r};
      default:    prdata = {{(32 - CFG_H_W){1'b0}}, height_r};
    endcase
  end

  // Effective frame size: zero reads as one, width saturates at MAX_WIDTH
  logic [EW-1:0]      width_x, eff_w, w_m1;
  logic [CFG_H_W-1:0] eff_h, h_m1;

  always_comb begin
    width_x = EW'(width_r);
    if (width_x == '0) begin
      eff_w = EW'(1);
    end else if (width_x > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = width_x;
    end
    w_m1  = eff_w - 1'b1;
    eff_h = (height_r == '0) ? CFG_H_W'(1) : height_r;
    h_m1  = eff_h - 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Frame position: input side (in_row/in_col) and output side (orow/ocol)
  // ---------------------------------------------------------------------------
  logic [ROW_W:0]   in_row_r, in_row_nxt;   // one extra bit: reaches height + 1
  logic [CW-1:0]    in_col_r, in_col_nxt;
  logic [ROW_W-1:0] orow_r, orow_nxt;
  logic [CW-1:0]    ocol_r, ocol_nxt;

  logic in_acc, drain, proc, col_last, ocol_last, emit, last, interior;
  pix_t pix_in;

  logic [OQ_CNT_W-1:0] credits;
  oq_stat_t            oq_stat;
  logic                s1_v_r, s2_v_r, s3_v_r;

  assign credits  = oq_stat.count + OQ_CNT_W'(s1_v_r) + OQ_CNT_W'(s2_v_r)
                  + OQ_CNT_W'(s3_v_r);
  assign in_ready = (credits < OQ_CNT_W'(OQ_DEPTH));
  assign in_acc   = in_valid && in_ready;

  // past the last row every transaction is a drain step with zero data
  assign drain = (in_row_r >= {1'b0, eff_h});
  // a flush arriving before the frame is complete is dropped outright
  assign proc  = in_acc && (drain || (in_data.req_type == REQ_PIXEL));

  assign pix_in = drain ? '0 : {in_data.pixel_c2, in_data.pixel_c1, in_data.pixel_c0};

  assign col_last  = (EW'(in_col_r) == w_m1);
  assign ocol_last = (EW'(ocol_r) == w_m1);
  assign emit      = (in_row_r >= (ROW_W + 1)'(2))
                  || ((in_row_r == (ROW_W + 1)'(1)) && (in_col_r != '0));
  assign last      = ocol_last && (orow_r == h_m1);
  assign interior  = (orow_r != '0) && (orow_r < h_m1)
                  && (ocol_r != '0) && (EW'(ocol_r) < w_m1);

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    in_row_nxt = in_row_r;
    in_col_nxt = in_col_r;
    orow_nxt   = orow_r;
    ocol_nxt   = ocol_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_WIDTH:  width_nxt  = pwdata[CFG_W_W-1:0];
        default:    height_nxt = pwdata[CFG_H_W-1:0];
      endcase
      in_row_nxt = '0;
      in_col_nxt = '0;
      orow_nxt   = '0;
      ocol_nxt   = '0;
    end else if (proc) begin
      if (col_last) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
      if (emit) begin
        if (last) begin
          // frame done: next transaction starts a new frame
          in_row_nxt = '0;
          in_col_nxt = '0;
          orow_nxt   = '0;
          ocol_nxt   = '0;
        end else if (ocol_last) begin
          ocol_nxt = '0;
          orow_nxt = orow_r + 1'b1;
        end else begin
          ocol_nxt = ocol_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      in_row_r <= '0;
      in_col_r <= '0;
      orow_r   <= '0;
      ocol_r   <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      in_row_r <= in_row_nxt;
      in_col_r <= in_col_nxt;
      orow_r   <= orow_nxt;
      ocol_r   <= ocol_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line store read returns; write back the shifted column
  // ---------------------------------------------------------------------------
  logic        s1_emit_r;
  pix_t        s1_data_r;
  logic [CW-1:0] s1_col_r;
  tag_t        s1_tag_r;
  line_entry_t lm_rd, lm_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= proc;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      s1_emit_r         <= emit;
      s1_data_r         <= pix_in;
      s1_col_r          <= in_col_r;
      s1_tag_r.interior <= interior;
      s1_tag_r.last     <= last;
      s1_tag_r.row      <= orow_r;
      s1_tag_r.col      <= COL_OUT_W'(ocol_r);
    end
  end

  // new pixel goes to row a, the old row a moves down to row b
  assign lm_wr.a = s1_data_r;
  assign lm_wr.b = lm_rd.a;

  bf3_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (proc),
    .rd_addr (in_col_r),
    .wr_en   (s1_v_r),
    .wr_addr (s1_col_r),
    .wr_data (lm_wr),
    .rd_data (lm_rd)
  );

  // 3x3 window: column 2 is the newest; rows 0..2 top to bottom
  pix_t win_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (s1_v_r) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= lm_rd.b;
      win_r[1][2] <= lm_rd.a;
      win_r[2][2] <= s1_data_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: emitted pixels only. The border copy is the old center-right tap.
  // ---------------------------------------------------------------------------
  tag_t s2_tag_r;
  pix_t s2_border_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_tag_r    <= s1_tag_r;
      s2_border_r <= win_r[1][2];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: per-channel sums of the updated window
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] sum_c [3];
  logic [SUM_W-1:0] s3_sum_r [3];
  tag_t             s3_tag_r;
  pix_t             s3_border_r;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_c[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          sum_c[ch] = sum_c[ch] + SUM_W'(win_r[r][c][CH_W*ch +: CH_W]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      s3_tag_r    <= s2_tag_r;
      s3_border_r <= s2_border_r;
      for (int ch = 0; ch < 3; ch++) begin
        s3_sum_r[ch] <= sum_c[ch];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Divide by 9 (reciprocal multiply), pick mean or border copy, queue the result
  // ---------------------------------------------------------------------------
  logic [2*SUM_W-1:0] prod [3];
  pix_t               mean;
  out_item_t          res;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = (2 * SUM_W)'(s3_sum_r[ch]) * (2 * SUM_W)'(DIV9_MUL);
      mean[CH_W*ch +: CH_W] = prod[ch][DIV9_SHIFT +: CH_W];
    end
  end

  always_comb begin
    if (s3_tag_r.interior) begin
      res.out_c0 = mean[CH_W-1:0];
      res.out_c1 = mean[2*CH_W-1:CH_W];
      res.out_c2 = mean[3*CH_W-1:2*CH_W];
    end else begin
      res.out_c0 = s3_border_r[CH_W-1:0];
      res.out_c1 = s3_border_r[2*CH_W-1:CH_W];
      res.out_c2 = s3_border_r[3*CH_W-1:2*CH_W];
    end
    res.out_row   = s3_tag_r.row;
    res.out_col   = s3_tag_r.col;
    res.frame_end = s3_tag_r.last;
  end

  bf3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s3_v_r),
    .push_data (res),
    .pop       (out_valid && out_ready),
    .pop_data  (out_data),
    .stat      (oq_stat)
  );

  assign out_valid = !oq_stat.empty;

endmodule

`default_nettype wire

// ----- sv/bf3_checker.sv -----
// Port-level checks of the box filter top level, bound to it.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bf3_checker
  import bf3_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input in_item_t         in_data,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input out_item_t        out_data,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  // a held result keeps its data until taken
  `BF3_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // backpressure only while results are queued
  `BF3_ASSERT_IMP(a_stall_has_data, clk, rst_n, !in_ready, out_valid)

  // the port never inserts wait states
  `BF3_ASSERT_IMP(a_pready, clk, rst_n, 1'b1, pready)

  // width written last cycle reads back
  `BF3_ASSERT_IMP(a_width_rb, clk, rst_n, $past(psel && penable && pwrite && rst_n) && ($past(paddr[2]) == REG_WIDTH) && (paddr[2] == REG_WIDTH), prdata[CFG_W_W-1:0] == $past(pwdata[CFG_W_W-1:0]))

endmodule

bind box_filter_3x3_rgb_top bf3_checker u_bf3_checker (.*);

`default_nettype wire
